>>> rtl/core/ftp_reply_parser_assert.svh
// assertion helpers for the reply parser, clocked on clk with reset rst_n
`ifndef FTP_REPLY_PARSER_ASSERT_SVH
`define FTP_REPLY_PARSER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define FRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/frp_pkg.sv
package frp_pkg;

  localparam int unsigned LINE_KEEP_DEF = 512;

  localparam logic [15:0] DEADLINE_RST = 16'd6000;
  localparam logic [15:0] IDLE_RST     = 16'd1500;

  localparam logic [9:0] CODE_PASV = 10'd227;
  localparam logic [16:0] BYTE_MAX = 17'd255;
  localparam logic [2:0] DIGITS_MAX = 3'd5;
  localparam logic [2:0] FIELD_P1 = 3'd4;
  localparam logic [2:0] FIELD_P2 = 3'd5;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_DASH   = 8'h2d;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_BEGIN = 2'd2,
    CMD_CLOSE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_REPLY = 3'd1,
    ST_DEADLINE = 3'd2,
    ST_IDLE     = 3'd3,
    ST_CLOSED   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PH_SEEK   = 3'd0,
    PH_SKIP   = 3'd1,
    PH_DIGITS = 3'd2,
    PH_GOOD   = 3'd3,
    PH_BAD    = 3'd4
  } phase_t;

  typedef enum logic {
    CFG_DEADLINE = 1'b0,
    CFG_IDLE     = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  reply_code;
    logic        pasv_ok;
    logic [15:0] data_port;
  } out_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  field_index;
    logic [16:0] accum;
    logic [2:0]  digit_count;
    logic [7:0]  port_hi;
    logic [7:0]  port_lo;
  } scan_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

>>> rtl/core/ftp_reply_parser.sv
// throughput: one request per cycle, unless the result register is stalled
// each request goes from the input register through one update of the parse
// state into the result register
// reset: parser idle, line and scan state cleared, deadline 6000, idle limit 1500
module ftp_reply_parser #(
  parameter int unsigned LINE_KEEP = frp_pkg::LINE_KEEP_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  frp_pkg::in_t    in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output frp_pkg::out_t   out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_index,
  input  logic [15:0]     cfg_data
);
  import frp_pkg::*;

  localparam int unsigned POS_W = $clog2(LINE_KEEP);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_KEEP - 1);
  localparam logic [POS_W-1:0] POS_HEAD = POS_W'(4);

  logic        in_valid_r;
  in_t         in_data_r;
  logic        out_valid_r;
  out_t        out_data_r;
  logic        proc_go;

  logic [15:0] deadline_r;
  logic [15:0] idle_lim_r;

  logic             busy_r, busy_nxt;
  logic             first_r, first_nxt;
  logic             multi_r, multi_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       head_r [4];
  logic [7:0]       head_nxt [4];
  logic [7:0]       code_r [3];
  logic [7:0]       code_nxt [3];
  logic [15:0]      elapsed_r, elapsed_nxt;
  logic [15:0]      idle_r, idle_nxt;
  scan_t            scan_r, scan_nxt;

  logic             emit;
  out_t             res;

  function automatic scan_t scan_feed(input scan_t s, input logic [7:0] c);
    scan_t t;
    t = s;
    case (s.phase)
      PH_SEEK: begin
        if (c == CH_NUL) begin
          t.phase = PH_BAD;
        end else if (c == CH_LPAREN) begin
          t.phase = PH_SKIP;
          t.field_index = 3'd0;
        end
      end
      PH_SKIP: begin
        if (c == CH_SPACE) begin
          t.phase = PH_SKIP;
        end else if (is_digit(c)) begin
          t.accum = {13'd0, c[3:0]};
          t.digit_count = 3'd1;
          t.phase = PH_DIGITS;
        end else begin
          t.phase = PH_BAD;
        end
      end
      PH_DIGITS: begin
        if (is_digit(c) && (s.digit_count < DIGITS_MAX)) begin
          // times ten as two shifts
          t.accum = (s.accum << 3) + (s.accum << 1) + {13'd0, c[3:0]};
          t.digit_count = s.digit_count + 3'd1;
        end else if (s.accum > BYTE_MAX) begin
          t.phase = PH_BAD;
        end else begin
          if (s.field_index == FIELD_P1) t.port_hi = s.accum[7:0];
          if (s.field_index == FIELD_P2) t.port_lo = s.accum[7:0];
          if (s.field_index >= FIELD_P2) begin
            t.phase = PH_GOOD;
          end else if (c == CH_COMMA) begin
            t.field_index = s.field_index + 3'd1;
            t.accum = 17'd0;
            t.digit_count = 3'd0;
            t.phase = PH_SKIP;
          end else begin
            t.phase = PH_BAD;
          end
        end
      end
      default: begin
        t = s;
      end
    endcase
    return t;
  endfunction

  function automatic logic [9:0] code_value(input logic [7:0] d0, input logic [7:0] d1,
                                            input logic [7:0] d2);
    return 10'({6'd0, d0[3:0]} * 10'd100) + 10'({6'd0, d1[3:0]} * 10'd10) +
           {6'd0, d2[3:0]};
  endfunction

  assign proc_go   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !proc_go;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    logic [16:0] e_sum;
    logic [16:0] d_sum;
    logic [7:0]  c;
    logic        ok_end;
    logic        head_ok;
    logic        cont_end;
    logic [9:0]  code;
    scan_t       s_end;
    logic        pasv;

    busy_nxt    = busy_r;
    first_nxt   = first_r;
    multi_nxt   = multi_r;
    pos_nxt     = pos_r;
    head_nxt    = head_r;
    code_nxt    = code_r;
    elapsed_nxt = elapsed_r;
    idle_nxt    = idle_r;
    scan_nxt    = scan_r;
    emit        = 1'b0;
    res         = '0;

    c        = in_data_r.rx_byte;
    e_sum    = {1'b0, elapsed_r} + 17'd1;
    d_sum    = {1'b0, idle_r} + 17'd1;
    s_end    = scan_feed(scan_r, CH_NUL);
    head_ok  = is_digit(head_r[0]) && is_digit(head_r[1]) && is_digit(head_r[2]);
    cont_end = (head_r[0] == code_r[0]) && (head_r[1] == code_r[1]) &&
               (head_r[2] == code_r[2]) && (head_r[3] == CH_SPACE);
    // on the first line the code comes straight from the head characters
    code     = first_r ? code_value(head_r[0], head_r[1], head_r[2])
                       : code_value(code_r[0], code_r[1], code_r[2]);
    pasv     = (code == CODE_PASV) && (s_end.phase == PH_GOOD);
    ok_end   = 1'b0;

    case (cmd_t'(in_data_r.cmd))
      CMD_BEGIN: begin
        busy_nxt    = 1'b1;
        first_nxt   = 1'b1;
        multi_nxt   = 1'b0;
        pos_nxt     = '0;
        head_nxt    = '{default: 8'd0};
        code_nxt    = '{default: 8'd0};
        scan_nxt    = '{phase: PH_SEEK, default: '0};
        elapsed_nxt = 16'd0;
        idle_nxt    = 16'd0;
      end
      CMD_CLOSE: begin
        if (busy_r) begin
          emit       = 1'b1;
          res.status = ST_CLOSED;
        end
      end
      CMD_TICK: begin
        if (busy_r) begin
          if (e_sum > {1'b0, deadline_r}) begin
            emit       = 1'b1;
            res.status = ST_DEADLINE;
          end else if (d_sum > {1'b0, idle_lim_r}) begin
            emit       = 1'b1;
            res.status = ST_IDLE;
          end else begin
            elapsed_nxt = e_sum[15:0];
            idle_nxt    = d_sum[15:0];
          end
        end
      end
      CMD_BYTE: begin
        if (busy_r) begin
          idle_nxt = 16'd0;
          if (c == CH_LF) begin
            scan_nxt = s_end;
            if (first_r) begin
              if (!head_ok) begin
                emit       = 1'b1;
                res.status = ST_NO_REPLY;
              end else begin
                code_nxt[0] = head_r[0];
                code_nxt[1] = head_r[1];
                code_nxt[2] = head_r[2];
                multi_nxt   = (head_r[3] == CH_DASH);
                first_nxt   = 1'b0;
                ok_end      = (head_r[3] != CH_DASH);
              end
            end else begin
              ok_end = cont_end;
            end
            if (ok_end) begin
              emit           = 1'b1;
              res.status     = ST_OK;
              res.reply_code = code;
              res.pasv_ok    = pasv;
              res.data_port  = pasv ? {s_end.port_hi, s_end.port_lo} : 16'd0;
            end
            // line clear; port bytes stay with the reply
            pos_nxt  = '0;
            head_nxt = '{default: 8'd0};
            scan_nxt = '{phase: PH_SEEK, field_index: 3'd0, accum: 17'd0,
                         digit_count: 3'd0, port_hi: s_end.port_hi,
                         port_lo: s_end.port_lo};
          end else if ((c != CH_CR) && (pos_r < POS_LAST)) begin
            if (pos_r < POS_HEAD) head_nxt[pos_r[1:0]] = c;
            scan_nxt = scan_feed(scan_r, c);
            pos_nxt  = pos_r + POS_W'(1);
          end
        end
      end
      default: begin
        busy_nxt = busy_r;
      end
    endcase

    if (emit) busy_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      deadline_r  <= DEADLINE_RST;
      idle_lim_r  <= IDLE_RST;
      busy_r      <= 1'b0;
      first_r     <= 1'b1;
      multi_r     <= 1'b0;
      pos_r       <= '0;
      head_r      <= '{default: 8'd0};
      code_r      <= '{default: 8'd0};
      elapsed_r   <= 16'd0;
      idle_r      <= 16'd0;
      scan_r      <= '{phase: PH_SEEK, default: '0};
    end else begin
      if (in_valid && !in_stall) begin
        in_valid_r <= 1'b1;
      end else if (proc_go) begin
        in_valid_r <= 1'b0;
      end

      if (proc_go) begin
        out_valid_r <= emit;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_DEADLINE: deadline_r <= cfg_data;
          CFG_IDLE:     idle_lim_r <= cfg_data;
          default:      deadline_r <= deadline_r;
        endcase
      end

      if (proc_go) begin
        busy_r    <= busy_nxt;
        first_r   <= first_nxt;
        multi_r   <= multi_nxt;
        pos_r     <= pos_nxt;
        head_r    <= head_nxt;
        code_r    <= code_nxt;
        elapsed_r <= elapsed_nxt;
        idle_r    <= idle_nxt;
        scan_r    <= scan_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_data_r <= in_data;
    if (proc_go && emit) out_data_r <= res;
  end

`include "ftp_reply_parser_assert.svh"

  `FRP_ASSERT_NOW(a_pasv_code, out_valid_r && out_data_r.pasv_ok, (out_data_r.status == ST_OK) && (out_data_r.reply_code == CODE_PASV), "pasv result without ok status and code 227")
  `FRP_ASSERT_NOW(a_err_clean, out_valid_r && (out_data_r.status != ST_OK), (out_data_r.reply_code == 10'd0) && !out_data_r.pasv_ok && (out_data_r.data_port == 16'd0), "error result carries reply fields")
  `FRP_ASSERT_NEXT(a_emit_out, proc_go && emit, out_valid_r, "result lost on its way to the output register")
  `FRP_ASSERT_NEXT(a_begin_busy, proc_go && (in_data_r.cmd == CMD_BEGIN), busy_r && first_r && (pos_r == '0), "begin request did not open a reply")
  `FRP_ASSERT_NEXT(a_idle_no_out, proc_go && !busy_r && (in_data_r.cmd != CMD_BEGIN), !busy_r && (out_valid_r == $past(out_valid_r && out_stall)), "idle parser produced a result")

endmodule

>>> sim/testbench.sv
module testbench;
  import frp_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned SHOW_MAX = 10;
  localparam int unsigned ITEMS_PER_SETTING = 210;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  ftp_reply_parser i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // reply parser prediction state
  logic [15:0] deadline_lim;
  logic [15:0] idle_lim;
  logic        in_reply;
  logic        on_first_line;
  logic        multi_line;
  int unsigned col;
  logic [7:0]  head [4];
  logic [7:0]  code_chars [3];
  int unsigned ticks_total;
  int unsigned ticks_quiet;
  phase_t      scan_ph;
  int unsigned num_idx;
  int unsigned num_val;
  int unsigned num_len;
  logic [7:0]  port_hi;
  logic [7:0]  port_lo;

  out_t        reply_q [$];
  int unsigned mismatches = 0;
  int unsigned reply_items = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;
  int unsigned tick_pct = 0;
  int unsigned tick_run = 1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit numeral(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void clear_scan();
    scan_ph = PH_SEEK;
    num_idx = 0;
    num_val = 0;
    num_len = 0;
  endfunction

  function automatic void clear_line();
    col = 0;
    for (int k = 0; k < 4; k++) head[k] = '0;
    clear_scan();
  endfunction

  function automatic void reset_parser();
    deadline_lim = DEADLINE_RST;
    idle_lim = IDLE_RST;
    in_reply = 1'b0;
    on_first_line = 1'b1;
    multi_line = 1'b0;
    clear_line();
    for (int k = 0; k < 3; k++) code_chars[k] = '0;
    ticks_total = 0;
    ticks_quiet = 0;
    port_hi = '0;
    port_lo = '0;
  endfunction

  // a nul byte stands for the end of the line
  function automatic void scan_char(input logic [7:0] c);
    case (scan_ph)
      PH_SEEK: begin
        if (c == CH_NUL) begin
          scan_ph = PH_BAD;
        end else if (c == CH_LPAREN) begin
          scan_ph = PH_SKIP;
          num_idx = 0;
        end
      end
      PH_SKIP: begin
        if (c != CH_SPACE) begin
          if (numeral(c)) begin
            num_val = int'(c) - int'(CH_ZERO);
            num_len = 1;
            scan_ph = PH_DIGITS;
          end else begin
            scan_ph = PH_BAD;
          end
        end
      end
      PH_DIGITS: begin
        if (numeral(c) && num_len < DIGITS_MAX) begin
          num_val = num_val * 10 + (int'(c) - int'(CH_ZERO));
          num_len++;
        end else if (num_val > BYTE_MAX) begin
          scan_ph = PH_BAD;
        end else begin
          if (num_idx == FIELD_P1) port_hi = num_val[7:0];
          if (num_idx == FIELD_P2) port_lo = num_val[7:0];
          if (num_idx >= FIELD_P2) begin
            scan_ph = PH_GOOD;
          end else if (c == CH_COMMA) begin
            num_idx++;
            num_val = 0;
            num_len = 0;
            scan_ph = PH_SKIP;
          end else begin
            scan_ph = PH_BAD;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void reply_ok(output out_t r);
    int unsigned code;
    code = (int'(code_chars[0]) - int'(CH_ZERO)) * 100 +
           (int'(code_chars[1]) - int'(CH_ZERO)) * 10 +
           (int'(code_chars[2]) - int'(CH_ZERO));
    r = '0;
    r.status = ST_OK;
    r.reply_code = code[9:0];
    r.pasv_ok = (code == CODE_PASV) && (scan_ph == PH_GOOD);
    if (r.pasv_ok) r.data_port = {port_hi, port_lo};
    in_reply = 1'b0;
  endfunction

  function automatic bit end_of_line(output out_t r);
    bit got;
    got = 1'b0;
    r = '0;
    scan_char(CH_NUL);
    if (on_first_line) begin
      if (!(numeral(head[0]) && numeral(head[1]) && numeral(head[2]))) begin
        r.status = ST_NO_REPLY;
        in_reply = 1'b0;
        got = 1'b1;
      end else begin
        for (int k = 0; k < 3; k++) code_chars[k] = head[k];
        multi_line = (head[3] == CH_DASH);
        on_first_line = 1'b0;
        if (!multi_line) begin
          reply_ok(r);
          got = 1'b1;
        end
      end
    end else if (head[0] == code_chars[0] && head[1] == code_chars[1] &&
                 head[2] == code_chars[2] && head[3] == CH_SPACE) begin
      reply_ok(r);
      got = 1'b1;
    end
    clear_line();
    return got;
  endfunction

  function automatic bit parse_step(input in_t x, output out_t r);
    r = '0;
    if (x.cmd == CMD_BEGIN) begin
      in_reply = 1'b1;
      on_first_line = 1'b1;
      multi_line = 1'b0;
      clear_line();
      for (int k = 0; k < 3; k++) code_chars[k] = '0;
      port_hi = '0;
      port_lo = '0;
      ticks_total = 0;
      ticks_quiet = 0;
      return 1'b0;
    end
    if (!in_reply) return 1'b0;
    if (x.cmd == CMD_CLOSE) begin
      r.status = ST_CLOSED;
      in_reply = 1'b0;
      return 1'b1;
    end
    if (x.cmd == CMD_TICK) begin
      // deadline is checked first, so it wins a tie with the idle limit
      if (ticks_total + 1 > deadline_lim) begin
        r.status = ST_DEADLINE;
        in_reply = 1'b0;
        return 1'b1;
      end
      if (ticks_quiet + 1 > idle_lim) begin
        r.status = ST_IDLE;
        in_reply = 1'b0;
        return 1'b1;
      end
      ticks_total++;
      ticks_quiet++;
      return 1'b0;
    end
    ticks_quiet = 0;
    if (x.rx_byte == CH_LF) return end_of_line(r);
    if (x.rx_byte == CH_CR) return 1'b0;
    if (col < LINE_KEEP_DEF - 1) begin
      if (col < 4) head[col] = x.rx_byte;
      scan_char(x.rx_byte);
      col++;
    end
    return 1'b0;
  endfunction

  // result checking
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (reply_q.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_MAX)
          $display("%0t: result with nothing expected: status %0d code %0d pasv %0d port %0d",
                   $realtime, out_data.status, out_data.reply_code, out_data.pasv_ok,
                   out_data.data_port);
      end else begin
        want = reply_q.pop_front();
        if (out_data.status !== want.status || out_data.reply_code !== want.reply_code ||
            out_data.pasv_ok !== want.pasv_ok || out_data.data_port !== want.data_port) begin
          mismatches++;
          if (mismatches <= SHOW_MAX)
            $display("%0t: expected status %0d code %0d pasv %0d port %0d, got %0d %0d %0d %0d",
                     $realtime, want.status, want.reply_code, want.pasv_ok, want.data_port,
                     out_data.status, out_data.reply_code, out_data.pasv_ok,
                     out_data.data_port);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(99) < recv_gap_pct);
    end
  end

  task automatic send(input cmd_t cmd, input logic [7:0] b);
    in_t  x;
    out_t r;
    x.cmd = cmd;
    x.rx_byte = b;
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = x;
    do @(posedge clk); while (in_stall);
    if (cmd == CMD_BEGIN || in_reply) reply_items++;
    if (parse_step(x, r)) reply_q.push_back(r);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    // requests that give no result may still be in flight
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_DEADLINE) deadline_lim = v;
    else idle_lim = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_limits(input logic [15:0] deadline, input logic [15:0] idle);
    if (in_reply) send(CMD_CLOSE, 8'($urandom_range(255)));
    drain();
    write_reg(CFG_DEADLINE, deadline);
    write_reg(CFG_IDLE, idle);
  endtask

  task automatic put_ticks(input int unsigned n);
    repeat (n) send(CMD_TICK, 8'($urandom_range(255)));
  endtask

  task automatic put_byte(input logic [7:0] c);
    if ($urandom_range(99) < tick_pct) put_ticks($urandom_range(1, tick_run));
    send(CMD_BYTE, c);
  endtask

  task automatic put_text(input string s);
    int unsigned k;
    for (k = 0; k < s.len(); k++) put_byte(s[k]);
  endtask

  task automatic put_rand_text(input int unsigned n);
    repeat (n) put_byte(8'($urandom_range(8'h20, 8'h7e)));
  endtask

  task automatic put_eol();
    if ($urandom_range(2) == 0) put_byte(CH_CR);
    put_byte(CH_LF);
  endtask

  task automatic put_num(input int unsigned v);
    if ($urandom_range(7) == 0) repeat ($urandom_range(1, 3)) put_byte(CH_ZERO);
    put_text($sformatf("%0d", v));
  endtask

  task automatic put_addr_list();
    int unsigned k;
    int unsigned pick;
    put_byte(CH_LPAREN);
    for (k = 0; k < 6; k++) begin
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) put_byte(CH_SPACE);
      pick = $urandom_range(19);
      if (pick < 2) put_num(0);
      else if (pick < 4) put_num(255);
      else if (pick == 4) put_num($urandom_range(256, 999));
      else if (pick == 5) put_num($urandom_range(1000, 99999));
      else put_num($urandom_range(255));
      if (k < 5) begin
        case ($urandom_range(24))
          0: put_byte(CH_SPACE);
          1: put_byte(";");
          2: put_byte("x");
          default: put_byte(CH_COMMA);
        endcase
      end
    end
    if ($urandom_range(3) != 0) put_byte(")");
  endtask

  // one reply, mostly well formed, with random content and tick spacing
  task automatic gen_reply();
    string       code;
    int unsigned n;
    tick_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(2, 30);
    tick_run = $urandom_range(1, 12);
    send(CMD_BEGIN, 8'($urandom_range(255)));
    code = ($urandom_range(2) == 0) ? "227" : $sformatf("%03d", $urandom_range(999));
    case ($urandom_range(9))
      0, 1, 2: begin
        if ($urandom_range(4) != 0) code = "227";
        put_text(code);
        put_text($urandom_range(1) ? " Entering Passive Mode " : " ");
        put_addr_list();
        put_eol();
      end
      3, 4: begin
        put_text(code);
        case ($urandom_range(2))
          0: put_byte(CH_SPACE);
          1: put_byte("x");
          default: ;
        endcase
        put_rand_text($urandom_range(8));
        put_eol();
      end
      5: begin
        put_text(code);
        put_byte(CH_DASH);
        put_rand_text($urandom_range(6));
        put_eol();
        n = $urandom_range(3);
        repeat (n) begin
          case ($urandom_range(5))
            0: put_rand_text($urandom_range(1, 8));
            1: begin
              put_text(code);
              put_byte(CH_DASH);
            end
            2: put_byte(code[0]);
            3: begin
              put_text($sformatf("%03d", $urandom_range(999)));
              put_byte(CH_SPACE);
            end
            4: begin
              put_text(code);
              put_byte("x");
            end
            default: begin
              put_byte(CH_SPACE);
              put_addr_list();
            end
          endcase
          put_eol();
        end
        if ($urandom_range(4) != 0) begin
          put_text(code);
          put_byte(CH_SPACE);
          if ($urandom_range(1)) put_addr_list();
          put_rand_text($urandom_range(4));
          put_eol();
        end
      end
      6: begin
        case ($urandom_range(4))
          0: ;
          1: put_byte("2");
          2: put_text("22");
          3: put_text("2a7 x");
          default: put_text(" 227 x");
        endcase
        put_eol();
      end
      7: begin
        put_ticks($urandom_range(1, 20));
        if ($urandom_range(1)) send(CMD_CLOSE, 8'($urandom_range(255)));
      end
      8: begin
        repeat ($urandom_range(1, 20)) put_byte(8'($urandom_range(255)));
        put_byte(CH_LF);
      end
      default: begin
        // left open; unless the close or line end sent after it ends it, the next begin abandons it
        put_text(code);
        put_rand_text($urandom_range(4));
      end
    endcase
    case ($urandom_range(7))
      0: send(CMD_CLOSE, 8'($urandom_range(255)));
      1: put_ticks($urandom_range(1, 3));
      2: begin
        put_byte("x");
        put_byte(CH_LF);
      end
      default: ;
    endcase
  endtask

  task automatic test_idle_parser();
    tick_pct = 0;
    send(CMD_CLOSE, 8'hff);
    send(CMD_TICK, 8'h00);
    send(CMD_BYTE, 8'hff);
    send(CMD_BYTE, CH_LF);
  endtask

  task automatic test_basic_replies();
    tick_pct = 0;
    send(CMD_BEGIN, 8'h00);
    put_text("999");
    put_byte(CH_CR);
    put_byte(CH_LF);
    send(CMD_BEGIN, 8'hff);
    put_text("000");
    put_byte(CH_LF);
    send(CMD_BEGIN, 8'h00);
    put_byte("2");
    put_byte(CH_LF);
    send(CMD_BEGIN, 8'h00);
    put_byte(CH_LF);
    send(CMD_BEGIN, 8'h00);
    put_byte(8'hff);
    send(CMD_CLOSE, 8'h00);
    send(CMD_BEGIN, 8'h00);
    put_byte("1");
    send(CMD_BEGIN, 8'h00);
    put_text("123");
    put_byte(CH_LF);
  endtask

  task automatic test_timeout_tie();
    set_limits(16'd1, 16'd1);
    tick_pct = 0;
    send(CMD_BEGIN, 8'h00);
    put_ticks(2);
  endtask

  // a line that may run past the kept length, with ticks between its bytes
  task automatic test_long_lines();
    set_limits(16'hffff, 16'd3);
    tick_pct = 10;
    tick_run = 2;
    send(CMD_BEGIN, 8'h00);
    put_text("227 ");
    repeat ($urandom_range(490, 530)) put_byte(8'($urandom_range("a", "z")));
    put_addr_list();
    put_eol();
  endtask

  task automatic test_random_replies(input logic [15:0] deadline, input logic [15:0] idle);
    set_limits(deadline, idle);
    reply_items = 0;
    while (reply_items < ITEMS_PER_SETTING) gen_reply();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_DEADLINE;
    cfg_data = '0;
    reset_parser();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_gap_pct = 18;
    recv_gap_pct = 61;
    test_idle_parser();
    test_basic_replies();
    test_timeout_tie();
    test_long_lines();
    test_random_replies(16'hffff, 16'hffff);

    send_gap_pct = 61;
    recv_gap_pct = 18;
    test_random_replies(16'd40, 16'd8);
    test_random_replies(16'd12, 16'd12);

    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_random_replies(16'($urandom_range(20, 200)), 16'($urandom_range(5, 50)));
    test_random_replies(DEADLINE_RST, IDLE_RST);

    drain();
    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
